// ===== design/cleb_pkg.sv =====
// Shared constants and types of the command line edit buffer.
package cleb_pkg;

	localparam int LINE_LEN    = 64;
	localparam int STORE_DEPTH = 64;
	localparam int IDX_W       = 6;
	localparam int CHAR_W      = 7;
	localparam int KEY_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int SCAN_W      = 7;

	// Longest line length; a line takes an insert only while it is shorter
	localparam int FULL_LIMIT  = (LINE_LEN - 1 < STORE_DEPTH - 1) ? LINE_LEN - 1
	                                                              : STORE_DEPTH - 1;

	localparam logic [KEY_W-1:0] KEY_ESCAPE    = 8'd27;
	localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
	localparam logic [KEY_W-1:0] PRINT_LOW     = 8'd32;
	localparam logic [KEY_W-1:0] PRINT_HIGH    = 8'd126;

	localparam logic [KEY_W-1:0] RST_CURSOR_LEFT  = 8'd250;
	localparam logic [KEY_W-1:0] RST_CURSOR_RIGHT = 8'd251;
	localparam logic [KEY_W-1:0] RST_DELETE_FWD   = 8'd252;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CURSOR_LEFT  = 2'd0,
		CFG_CURSOR_RIGHT = 2'd1,
		CFG_DELETE_FWD   = 2'd2
	} cleb_cfg_idx_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_LOAD
	} cleb_cell_op_t;

	typedef struct packed {
		cleb_cell_op_t op;
		logic          rd_take;
	} cleb_cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} cleb_state_t;

	localparam logic [0:0] CMD_KEY  = 1'b0;
	localparam logic [0:0] CMD_READ = 1'b1;

endpackage

// ===== design/cleb_cell.sv =====
// One character cell of the edit buffer chain, with its read pass-through stage.
module cleb_cell import cleb_pkg::*; (
	input  logic              clk,
	input  cleb_cell_ctrl_t   ctrl,
	input  logic [CHAR_W-1:0] left_char,
	input  logic [CHAR_W-1:0] right_char,
	input  logic [CHAR_W-1:0] new_char,
	input  logic [CHAR_W-1:0] rd_in,
	output logic [CHAR_W-1:0] char_q,
	output logic [CHAR_W-1:0] rd_q
);

	// Hold, shift from a neighbour or load the typed character
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_HOLD:       char_q <= char_q;
			CELL_FROM_LEFT:  char_q <= left_char;
			CELL_FROM_RIGHT: char_q <= right_char;
			CELL_LOAD:       char_q <= new_char;
			default:         char_q <= char_q;
		endcase
	end

	// Pass read data down the chain, or inject own character
	always_ff @(posedge clk) begin
		rd_q <= ctrl.rd_take ? char_q : rd_in;
	end

endmodule

// ===== design/command_line_edit_buffer.sv =====
// Top level of the command line edit buffer: control, registers and the cell chain.
//
// Usage:
//   Commands are transferred at a rising edge with start high and busy low.
//   command = key event: the key is applied at the transfer; done pulses on the
//   next cycle with handled, active, cursor_pos and line_length. busy stays
//   low, so one key per cycle may be issued.
//   command = read: the character read travels down the chain of 64 cells,
//   one cell per cycle, into cell 0. busy is high for the whole scan and done
//   pulses as busy falls; read_char is 0 at or past the line length.
//   Each result is shown for exactly one cycle on done; the receiver cannot
//   stall, so nothing is queued.
//   Configuration: cfg_write with cfg_index and cfg_data sets the cursor-left,
//   cursor-right and forward-delete key codes; index 3 is ignored. Write only
//   while the block is idle.
//   Reset (arst_n low) clears the line, deactivates editing and restores the
//   default key codes. Character storage is not cleared; only positions below
//   the length are ever read.
module command_line_edit_buffer import cleb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [0:0]           command,
	input  logic [KEY_W-1:0]     key_code,
	input  logic [IDX_W-1:0]     read_index,
	output logic                 done,
	output logic                 handled,
	output logic                 active,
	output logic [IDX_W-1:0]     cursor_pos,
	output logic [IDX_W-1:0]     line_length,
	output logic [CHAR_W-1:0]    read_char,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data
);

	cleb_state_t state_q, state_d;

	logic [KEY_W-1:0]  key_left_q, key_right_q, key_del_q;
	logic              active_q, active_d;
	logic [IDX_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  cursor_q, cursor_d;
	logic              handled_q, handled_d;
	logic              done_q, done_d;
	logic [CHAR_W-1:0] rdc_q, rdc_d;
	logic [IDX_W-1:0]  idx_q;
	logic [SCAN_W-1:0] scan_q;
	logic              scan_last;

	logic              accept, key_go, read_go;
	logic              printable;
	logic              op_ins, op_rem;
	logic [IDX_W-1:0]  ins_pos, ins_end, rem_pos;
	logic [CHAR_W-1:0] new_char;

	cleb_cell_ctrl_t   ctrl [STORE_DEPTH];
	logic [CHAR_W-1:0] chars [STORE_DEPTH];
	logic [CHAR_W-1:0] rds [STORE_DEPTH];

	assign accept    = start && !busy;
	assign key_go    = accept && (command == CMD_KEY);
	assign read_go   = accept && (command == CMD_READ);
	assign scan_last = (scan_q == SCAN_W'(STORE_DEPTH));
	assign new_char  = key_code[CHAR_W-1:0];

	always_comb begin
		printable = key_code inside {[PRINT_LOW:PRINT_HIGH]};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (read_go) begin
				state_d = ST_SCAN;
			end
			ST_SCAN: if (scan_last) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_SCAN: busy = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	// Decode a key event into line state updates and chain operations
	always_comb begin
		active_d  = active_q;
		count_d   = count_q;
		cursor_d  = cursor_q;
		handled_d = 1'b0;
		op_ins    = 1'b0;
		op_rem    = 1'b0;
		ins_pos   = cursor_q;
		ins_end   = count_q;
		rem_pos   = cursor_q;
		if (key_go) begin
			if (!active_q) begin
				if (printable) begin
					handled_d = 1'b1;
					active_d  = 1'b1;
					count_d   = IDX_W'(1);
					cursor_d  = IDX_W'(1);
					op_ins    = 1'b1;
					ins_pos   = '0;
					ins_end   = '0;
				end
			end else begin
				handled_d = 1'b1;
				if (key_code == KEY_ESCAPE) begin
					active_d = 1'b0;
					count_d  = '0;
					cursor_d = '0;
				end else if (key_code == key_left_q) begin
					if (cursor_q != '0) cursor_d = cursor_q - IDX_W'(1);
				end else if (key_code == key_right_q) begin
					if (cursor_q < count_q) cursor_d = cursor_q + IDX_W'(1);
				end else if (key_code == KEY_BACKSPACE) begin
					if (cursor_q != '0 && count_q != '0) begin
						op_rem   = 1'b1;
						rem_pos  = cursor_q - IDX_W'(1);
						count_d  = count_q - IDX_W'(1);
						cursor_d = cursor_q - IDX_W'(1);
					end
				end else if (key_code == key_del_q) begin
					if (cursor_q < count_q) begin
						op_rem  = 1'b1;
						count_d = count_q - IDX_W'(1);
					end
				end else if (printable) begin
					if (count_q < IDX_W'(FULL_LIMIT)) begin
						op_ins   = 1'b1;
						count_d  = count_q + IDX_W'(1);
						cursor_d = cursor_q + IDX_W'(1);
					end
				end else begin
					handled_d = 1'b0;
				end
			end
		end
	end

	// Result of a key event or a finished read
	always_comb begin
		done_d = key_go || (state_q == ST_SCAN && scan_last);
		rdc_d  = rdc_q;
		if (key_go) begin
			rdc_d = '0;
		end else if (state_q == ST_SCAN && scan_last) begin
			rdc_d = (idx_q < count_q) ? rds[0] : '0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 1'b0;
			count_q   <= '0;
			cursor_q  <= '0;
			handled_q <= 1'b0;
			done_q    <= 1'b0;
			scan_q    <= '0;
		end else begin
			state_q   <= state_d;
			active_q  <= active_d;
			count_q   <= count_d;
			cursor_q  <= cursor_d;
			done_q    <= done_d;
			if (key_go || read_go) handled_q <= handled_d;
			if (read_go) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
		end
	end

	// Result and read index payload
	always_ff @(posedge clk) begin
		rdc_q <= rdc_d;
		if (read_go) idx_q <= read_index;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_left_q  <= RST_CURSOR_LEFT;
			key_right_q <= RST_CURSOR_RIGHT;
			key_del_q   <= RST_DELETE_FWD;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_CURSOR_LEFT:  key_left_q  <= cfg_data;
				CFG_CURSOR_RIGHT: key_right_q <= cfg_data;
				CFG_DELETE_FWD:   key_del_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Cell chain
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		logic [CHAR_W-1:0] left_c, right_c, rd_in_c;

		if (i == 0) begin : g_first
			assign left_c = '0;
		end else begin : g_mid_l
			assign left_c = chars[i-1];
		end
		if (i == STORE_DEPTH - 1) begin : g_last
			assign right_c = '0;
			assign rd_in_c = '0;
		end else begin : g_mid_r
			assign right_c = chars[i+1];
			assign rd_in_c = rds[i+1];
		end

		// Select this cell's operation from its place against cursor and length
		always_comb begin
			ctrl[i].op      = CELL_HOLD;
			ctrl[i].rd_take = (state_q == ST_SCAN) && (idx_q == IDX_W'(i));
			if (op_ins) begin
				if (IDX_W'(i) == ins_pos) begin
					ctrl[i].op = CELL_LOAD;
				end else if (IDX_W'(i) > ins_pos && IDX_W'(i) <= ins_end) begin
					ctrl[i].op = CELL_FROM_LEFT;
				end
			end else if (op_rem) begin
				if (IDX_W'(i) >= rem_pos && (SCAN_W'(i) + SCAN_W'(1)) < {1'b0, count_q}) begin
					ctrl[i].op = CELL_FROM_RIGHT;
				end
			end
		end

		cleb_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.left_char  (left_c),
			.right_char (right_c),
			.new_char   (new_char),
			.rd_in      (rd_in_c),
			.char_q     (chars[i]),
			.rd_q       (rds[i])
		);
	end

	assign done        = done_q;
	assign handled     = handled_q;
	assign active      = active_q;
	assign cursor_pos  = cursor_q;
	assign line_length = count_q;
	assign read_char   = rdc_q;

	// Cursor never passes the end of the line
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("cursor beyond line length");

	// Length never passes the insert limit
	a_length_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IDX_W'(FULL_LIMIT))
		else $error("line length beyond limit");

	// An inactive buffer holds an empty line
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (count_q == '0 && cursor_q == '0))
		else $error("inactive buffer not empty");

	// A read transfer starts the scan
	a_read_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_READ) |=> (busy && !done))
		else $error("read did not start scan");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the command line edit buffer: directed table, then random keys and reads.
module testbench;
	import cleb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int                   CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

	typedef struct packed {
		logic              handled;
		logic              active;
		logic [IDX_W-1:0]  cursor;
		logic [IDX_W-1:0]  length;
		logic [CHAR_W-1:0] rchar;
	} edit_result_t;

	typedef struct packed {
		logic [0:0]       cmd;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
		logic [7:0]       reps;
		logic             typed;
		edit_result_t     want;
	} key_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [0:0]           command;
	logic [KEY_W-1:0]     key_code;
	logic [IDX_W-1:0]     read_index;
	logic                 done;
	logic                 handled;
	logic                 active;
	logic [IDX_W-1:0]     cursor_pos;
	logic [IDX_W-1:0]     line_length;
	logic [CHAR_W-1:0]    read_char;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0]     cfg_data;

	// Shadow copy of the line and the key registers
	logic [CHAR_W-1:0] line_shadow [STORE_DEPTH];
	logic              edit_on;
	logic [IDX_W-1:0]  text_len;
	logic [IDX_W-1:0]  caret;
	logic [KEY_W-1:0]  left_key;
	logic [KEY_W-1:0]  right_key;
	logic [KEY_W-1:0]  del_key;

	edit_result_t pending_results [$];
	key_row_t     key_rows [$];
	int           fail_count;
	int           cycles = 0;
	bit           idle_on;

	command_line_edit_buffer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.key_code    (key_code),
		.read_index  (read_index),
		.done        (done),
		.handled     (handled),
		.active      (active),
		.cursor_pos  (cursor_pos),
		.line_length (line_length),
		.read_char   (read_char),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, want %0d", what, got, want);
		fail_count++;
	endtask

	function automatic bit is_printable(input logic [KEY_W-1:0] k);
		return k >= PRINT_LOW && k <= PRINT_HIGH;
	endfunction

	// Insert at the caret, shifting the tail right; drop once the line is full
	function automatic void insert_char(input logic [KEY_W-1:0] k);
		int i;
		if (text_len >= FULL_LIMIT)
			return;
		for (i = text_len; i > caret; i--)
			line_shadow[i] = line_shadow[i-1];
		line_shadow[caret] = k[CHAR_W-1:0];
		caret++;
		text_len++;
	endfunction

	// Remove one character, closing the gap from the right
	function automatic void remove_char(input int pos);
		int i;
		for (i = pos; i + 1 < text_len; i++)
			line_shadow[i] = line_shadow[i+1];
		text_len--;
	endfunction

	// Apply one command to the shadow line and return what the block should show
	function automatic edit_result_t apply_command(input logic [0:0] cmd,
			input logic [KEY_W-1:0] k, input logic [IDX_W-1:0] ix);
		edit_result_t r;
		logic         took;
		took    = 1'b0;
		r.rchar = '0;
		if (cmd == CMD_KEY) begin
			took = 1'b1;
			if (!edit_on) begin
				if (is_printable(k)) begin
					edit_on  = 1'b1;
					text_len = '0;
					caret    = '0;
					insert_char(k);
				end else begin
					took = 1'b0;
				end
			end else if (k == KEY_ESCAPE) begin
				edit_on  = 1'b0;
				text_len = '0;
				caret    = '0;
			end else if (k == left_key) begin
				if (caret > 0)
					caret--;
			end else if (k == right_key) begin
				if (caret < text_len)
					caret++;
			end else if (k == KEY_BACKSPACE) begin
				if (caret > 0 && text_len > 0) begin
					remove_char(caret - 1);
					caret--;
				end
			end else if (k == del_key) begin
				if (caret < text_len)
					remove_char(caret);
			end else if (is_printable(k)) begin
				insert_char(k);
			end else begin
				took = 1'b0;
			end
		end else if (ix < text_len) begin
			r.rchar = line_shadow[ix];
		end
		r.handled = took;
		r.active  = edit_on;
		r.cursor  = caret;
		r.length  = text_len;
		return r;
	endfunction

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		edit_result_t w;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				w = pending_results.pop_front();
				if (handled !== w.handled)
					report_mismatch("handled", handled, w.handled);
				if (active !== w.active)
					report_mismatch("active", active, w.active);
				if (cursor_pos !== w.cursor)
					report_mismatch("cursor_pos", cursor_pos, w.cursor);
				if (line_length !== w.length)
					report_mismatch("line_length", line_length, w.length);
				if (read_char !== w.rchar)
					report_mismatch("read_char", read_char, w.rchar);
			end
		end
	end

	task automatic add_row(input logic [0:0] cmd, input logic [KEY_W-1:0] k,
			input logic [IDX_W-1:0] ix, input int reps, input logic typed,
			input edit_result_t want);
		key_row_t row;
		row.cmd   = cmd;
		row.key   = k;
		row.idx   = ix;
		row.reps  = 8'(reps);
		row.typed = typed;
		row.want  = want;
		key_rows.push_back(row);
	endtask

	// Offer one command, idling first at random, and hold it until the transfer
	task automatic send_command(input logic [0:0] cmd, input logic [KEY_W-1:0] k,
			input logic [IDX_W-1:0] ix, input logic typed, input edit_result_t want);
		edit_result_t p;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 21) begin
			start = 1'b0;
			@(negedge clk);
		end
		command    = cmd;
		key_code   = k;
		read_index = ix;
		start      = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		p = apply_command(cmd, k, ix);
		pending_results.push_back(typed ? want : p);
	endtask

	// Drop start and hold until every pending result has come back
	task automatic wait_drained;
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_key_reg(input logic [CFG_IDX_W-1:0] ix, input logic [KEY_W-1:0] v);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = ix;
		cfg_data  = v;
		@(negedge clk);
		cfg_write = 1'b0;
		case (ix)
			CFG_CURSOR_LEFT:  left_key  = v;
			CFG_CURSOR_RIGHT: right_key = v;
			CFG_DELETE_FWD:   del_key   = v;
			default: ;
		endcase
	endtask

	initial begin
		int               i;
		int               n;
		int               ph;
		int               burst;
		int               sel;
		logic [KEY_W-1:0] k;
		logic [IDX_W-1:0] ix;

		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_KEY;
		key_code   = '0;
		read_index = '0;
		cfg_write  = 1'b0;
		cfg_index  = CFG_CURSOR_LEFT;
		cfg_data   = '0;
		fail_count = 0;
		idle_on    = 1'b1;
		burst      = 0;
		edit_on    = 1'b0;
		text_len   = '0;
		caret      = '0;
		left_key   = RST_CURSOR_LEFT;
		right_key  = RST_CURSOR_RIGHT;
		del_key    = RST_DELETE_FWD;
		for (i = 0; i < STORE_DEPTH; i++)
			line_shadow[i] = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle keys, activation, edges of the cursor, full line, escape
		add_row(CMD_READ, 8'd0,   6'd63, 1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_READ, 8'd255, 6'd0,  1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_KEY,  8'd0,   6'd0,  1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_KEY,  8'd255, 6'd0,  1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_KEY,  8'd31,  6'd0,  1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_KEY,  8'd127, 6'd0,  1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_KEY,  KEY_ESCAPE, 6'd0, 1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_KEY,  PRINT_HIGH, 6'd0, 1, 1'b1, '{1'b1, 1'b1, 6'd1, 6'd1, 7'd0});
		add_row(CMD_KEY,  PRINT_LOW,  6'd0, 1, 1'b1, '{1'b1, 1'b1, 6'd2, 6'd2, 7'd0});
		add_row(CMD_READ, 8'd0,   6'd0,  1, 1'b1, '{1'b0, 1'b1, 6'd2, 6'd2, 7'd126});
		add_row(CMD_KEY,  RST_CURSOR_LEFT,  6'd0, 3, 1'b0, '0);
		add_row(CMD_KEY,  KEY_BACKSPACE,    6'd0, 1, 1'b0, '0);
		add_row(CMD_KEY,  RST_CURSOR_RIGHT, 6'd0, 1, 1'b0, '0);
		add_row(CMD_KEY,  RST_DELETE_FWD,   6'd0, 2, 1'b0, '0);
		add_row(CMD_KEY,  KEY_BACKSPACE,    6'd0, 1, 1'b0, '0);
		add_row(CMD_KEY,  8'd200, 6'd0,  1, 1'b0, '0);
		add_row(CMD_KEY,  8'd65,  6'd0,  70, 1'b0, '0);
		add_row(CMD_KEY,  RST_CURSOR_LEFT,  6'd0, 5, 1'b0, '0);
		add_row(CMD_KEY,  8'd66,  6'd0,  1, 1'b0, '0);
		add_row(CMD_READ, 8'd0,   6'd62, 1, 1'b0, '0);
		add_row(CMD_READ, 8'd0,   6'd63, 1, 1'b0, '0);
		add_row(CMD_KEY,  KEY_ESCAPE, 6'd0, 1, 1'b1, '{1'b1, 1'b0, 6'd0, 6'd0, 7'd0});
		add_row(CMD_READ, 8'd0,   6'd5,  1, 1'b1, '{1'b0, 1'b0, 6'd0, 6'd0, 7'd0});

		foreach (key_rows[i])
			for (n = 0; n < key_rows[i].reps; n++)
				send_command(key_rows[i].cmd, key_rows[i].key, key_rows[i].idx,
				             key_rows[i].typed, key_rows[i].want);

		// Random phases, each under its own key register setting
		for (ph = 0; ph < 5; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					write_key_reg(CFG_CURSOR_LEFT, 8'd0);
					write_key_reg(CFG_CURSOR_RIGHT, 8'd255);
					write_key_reg(CFG_DELETE_FWD, 8'd127);
				end
				1: begin
					// Collisions: a printable left key, right over backspace, escape over delete
					write_key_reg(CFG_CURSOR_LEFT, 8'd97);
					write_key_reg(CFG_CURSOR_RIGHT, KEY_BACKSPACE);
					write_key_reg(CFG_DELETE_FWD, KEY_ESCAPE);
				end
				2: begin
					write_key_reg(CFG_CURSOR_LEFT, KEY_W'($urandom_range(255)));
					write_key_reg(CFG_CURSOR_RIGHT, KEY_W'($urandom_range(255)));
					write_key_reg(CFG_DELETE_FWD, KEY_W'($urandom_range(255)));
				end
				3: begin
					k = KEY_W'($urandom_range(PRINT_HIGH, PRINT_LOW));
					write_key_reg(CFG_CURSOR_LEFT, k);
					write_key_reg(CFG_CURSOR_RIGHT, k);
					write_key_reg(CFG_DELETE_FWD, k);
				end
				default: begin
					write_key_reg(CFG_CURSOR_LEFT, RST_CURSOR_LEFT);
					write_key_reg(CFG_CURSOR_RIGHT, RST_CURSOR_RIGHT);
					write_key_reg(CFG_DELETE_FWD, RST_DELETE_FWD);
				end
			endcase
			write_key_reg(CFG_SPARE, KEY_W'($urandom_range(255)));
			idle_on = (ph != 2);

			for (n = 0; n < 60; n++) begin
				// Hold off once mid-phase until the block has drained
				if (ph == 1 && n == 40)
					wait_drained();
				if (burst == 0 && $urandom_range(99) == 0)
					burst = $urandom_range(60, 20);
				if (burst == 0 && $urandom_range(99) < 15) begin
					k  = KEY_W'($urandom_range(255));
					ix = IDX_W'(($urandom_range(9) < 7) ? $urandom_range(text_len)
					                                    : $urandom_range(63));
					send_command(CMD_READ, k, ix, 1'b0, '0);
				end else begin
					sel = $urandom_range(999);
					if (burst > 0) begin
						burst--;
						k = KEY_W'($urandom_range(PRINT_HIGH, PRINT_LOW));
					end else if (sel < 500)
						k = KEY_W'($urandom_range(PRINT_HIGH, PRINT_LOW));
					else if (sel < 600)
						k = left_key;
					else if (sel < 700)
						k = right_key;
					else if (sel < 770)
						k = KEY_BACKSPACE;
					else if (sel < 840)
						k = del_key;
					else if (sel < 855)
						k = KEY_ESCAPE;
					else
						k = KEY_W'($urandom_range(255));
					send_command(CMD_KEY, k, IDX_W'($urandom_range(63)), 1'b0, '0);
				end
			end
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
